// ----- rtl/variant_stream_overlap_chunker_defines.svh -----
// Assertion macros shared by the chunker checker.
// Depends on nothing; every macro expects i_clk and i_rst_n in scope.
`ifndef VARIANT_STREAM_OVERLAP_CHUNKER_DEFINES_SVH
`define VARIANT_STREAM_OVERLAP_CHUNKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define VOC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define VOC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/voc_pkg.sv -----
// Shared types and constants of the variant stream overlap chunker.
// Used by every module of the block but the checker; depends on nothing.
`timescale 1ns / 1ps

package voc_pkg;

    // Depth of the character history and widths derived from it
    localparam int MAX_OVERLAP = 32;
    localparam int HIST_AW     = (MAX_OVERLAP > 1) ? $clog2(MAX_OVERLAP) : 1;

    // Field widths
    localparam int CH_W  = 8;
    localparam int OVL_W = 6;

    localparam logic [OVL_W-1:0] OVL_RESET = 6'd32;
    localparam logic [OVL_W-1:0] OVL_MAX   = OVL_W'(MAX_OVERLAP);

    // Brace characters
    localparam logic [CH_W-1:0] CH_OPEN  = 8'h7B;
    localparam logic [CH_W-1:0] CH_CLOSE = 8'h7D;

    // Scanner phase
    typedef enum logic [1:0] {
        PH_OUTSIDE,
        PH_INSIDE,
        PH_COUNT
    } t_phase;

    // Scanner decision for the accepted character
    typedef struct packed {
        logic starts;   // character opens a new chunk
        logic replay;   // chunk ends here and the overlap is replayed
    } t_scan;

    // One result beat
    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            starts;
        logic            last;
    } t_result;

endpackage

// ----- rtl/voc_hist.sv -----
// Character history: shift line of the last MAX_OVERLAP characters.
// Depends on voc_pkg.
`timescale 1ns / 1ps

module voc_hist (
    input  logic                        i_clk,
    input  logic                        i_shift,
    input  logic [voc_pkg::CH_W-1:0]    i_ch,
    input  logic [voc_pkg::HIST_AW-1:0] i_rd_idx,
    output logic [voc_pkg::CH_W-1:0]    o_rd_ch
);
    import voc_pkg::*;

    logic [CH_W-1:0] r_hist [MAX_OVERLAP];

    // Shift toward index zero, newest at the top
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            for (int i = 0; i < MAX_OVERLAP - 1; i++) begin
                r_hist[i] <= r_hist[i+1];
            end
            r_hist[MAX_OVERLAP-1] <= i_ch;
        end
    end

    // Replay tap
    assign o_rd_ch = r_hist[i_rd_idx];

endmodule

// ----- rtl/voc_scan.sv -----
// Brace scanner: tracks brace phase, plain-character count and chunk state.
// Depends on voc_pkg.
`timescale 1ns / 1ps

module voc_scan (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic [voc_pkg::CH_W-1:0]  i_ch,
    input  logic [voc_pkg::OVL_W-1:0] i_k,
    output voc_pkg::t_scan            o_scan
);
    import voc_pkg::*;

    t_phase           r_phase, n_phase;
    logic [OVL_W-1:0] r_count, n_count;
    logic             r_chunk_open, n_chunk_open;
    logic [OVL_W-1:0] count_inc;
    logic             done;
    logic             k_zero;

    assign count_inc = r_count + OVL_W'(1);
    assign k_zero    = (i_k == '0);

    // Chunk end decision
    always_comb begin
        case (r_phase)
            PH_INSIDE: done = (i_ch == CH_CLOSE) && k_zero;
            PH_COUNT:  done = (i_ch != CH_OPEN) && (count_inc >= i_k);
            default:   done = 1'b0;
        endcase
    end

    // Next state
    always_comb begin
        n_phase      = r_phase;
        n_count      = r_count;
        n_chunk_open = 1'b1;
        case (r_phase)
            PH_INSIDE: begin
                if (i_ch == CH_CLOSE) begin
                    n_phase = PH_COUNT;
                    n_count = '0;
                end
            end
            PH_COUNT: begin
                if (i_ch == CH_OPEN) begin
                    n_phase = PH_INSIDE;
                    n_count = '0;
                end else begin
                    n_count = count_inc;
                end
            end
            default: begin
                n_phase = (i_ch == CH_OPEN) ? PH_INSIDE : PH_OUTSIDE;
            end
        endcase
        if (done) begin
            n_phase      = PH_OUTSIDE;
            n_count      = '0;
            n_chunk_open = !k_zero;
        end
    end

    // Outputs
    always_comb begin
        o_scan.starts = !r_chunk_open;
        o_scan.replay = done && !k_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_OUTSIDE;
            r_count      <= '0;
            r_chunk_open <= 1'b0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_count      <= n_count;
            r_chunk_open <= n_chunk_open;
        end
    end

endmodule

// ----- rtl/voc_oreg.sv -----
// Result register in front of the output stream.
// Depends on voc_pkg.
`timescale 1ns / 1ps

module voc_oreg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  voc_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_valid,
    output voc_pkg::t_result o_res,
    output logic             o_free
);
    import voc_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Slot can take a new beat when empty or being drained this cycle
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ----- rtl/variant_stream_overlap_chunker.sv -----
// Variant stream overlap chunker, top level.
// Depends on voc_pkg, voc_hist, voc_scan and voc_oreg.
//
// Usage:
//   s_axis carries one character per request in tdata. m_axis returns every
//   character in tdata, tuser marks the first character of a chunk, tlast the
//   final beat caused by one input character. i_cfg_wr_en / i_cfg_wr_data set
//   the overlap length (values above 32 act as 32); write it while idle.
//   An accepted character shows on m_axis in the cycle after it is accepted.
//   Throughput: one character per cycle while m_axis does not stall. When a
//   chunk ends, the closing character is followed by overlap_len replayed
//   beats from the history shift line, one per cycle unless m_axis stalls,
//   and s_axis_tready stays low until the last of them is loaded.
//   Reset (synchronous, active low) empties the result register, clears the
//   scanner to outside braces with no chunk open and sets overlap_len to 32;
//   the history needs no clearing.
//   A stall on m_axis holds the result register; s_axis_tready drops in the
//   same cycle since it follows the free state of that register.
`timescale 1ns / 1ps

module variant_stream_overlap_chunker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_wr_en,
    input  logic [voc_pkg::OVL_W-1:0] i_cfg_wr_data,
    // input stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,   // [7:0] ch
    // result stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [7:0]                m_axis_tdata,   // [7:0] out_ch
    output logic                      m_axis_tuser,   // [0] starts_chunk
    output logic                      m_axis_tlast
);
    import voc_pkg::*;

    logic [OVL_W-1:0]   r_ovl;
    logic               r_replay;
    logic [HIST_AW-1:0] r_rep_j;

    logic [OVL_W-1:0]   k;
    logic [OVL_W-1:0]   rd_pos;
    logic [OVL_W-1:0]   j_inc;
    logic               rep_last;
    logic               in_acc;
    logic               out_free;
    logic               load;
    logic [CH_W-1:0]    hist_ch;
    t_scan              scan;
    t_result            res;
    t_result            out_res;

    // Effective overlap, clamped to the history depth
    assign k = (r_ovl > OVL_MAX) ? OVL_MAX : r_ovl;

    // Replay position: oldest of the last k characters first
    assign j_inc    = OVL_W'(r_rep_j) + OVL_W'(1);
    assign rd_pos   = OVL_MAX - k + OVL_W'(r_rep_j);
    assign rep_last = (j_inc == k);

    assign s_axis_tready = !r_replay && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Result mux: replay beat or pass-through character
    always_comb begin
        if (r_replay) begin
            res.ch     = hist_ch;
            res.starts = (r_rep_j == '0);
            res.last   = rep_last;
            load       = 1'b1;
        end else begin
            res.ch     = s_axis_tdata;
            res.starts = scan.starts;
            res.last   = !scan.replay;
            load       = in_acc;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovl <= OVL_RESET;
        end else if (i_cfg_wr_en) begin
            r_ovl <= i_cfg_wr_data;
        end
    end

    // Replay sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_replay <= 1'b0;
            r_rep_j  <= '0;
        end else if (r_replay) begin
            if (out_free) begin
                r_replay <= !rep_last;
                r_rep_j  <= j_inc[HIST_AW-1:0];
            end
        end else if (in_acc && scan.replay) begin
            r_replay <= 1'b1;
            r_rep_j  <= '0;
        end
    end

    voc_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_acc),
        .i_ch     (s_axis_tdata),
        .i_k      (k),
        .o_scan   (scan)
    );

    voc_hist u_hist (
        .i_clk    (i_clk),
        .i_shift  (in_acc),
        .i_ch     (s_axis_tdata),
        .i_rd_idx (rd_pos[HIST_AW-1:0]),
        .o_rd_ch  (hist_ch)
    );

    voc_oreg u_oreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_res   (res),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_res   (out_res),
        .o_free  (out_free)
    );

    assign m_axis_tdata = out_res.ch;
    assign m_axis_tuser = out_res.starts;
    assign m_axis_tlast = out_res.last;

endmodule

// ----- rtl/voc_checker.sv -----
// Port-level checks of the chunker, bound to the top level.
// Depends on variant_stream_overlap_chunker_defines.svh and the top level ports.
`timescale 1ns / 1ps
`include "variant_stream_overlap_chunker_defines.svh"

module voc_sva (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_wr_en,
    input logic [5:0] i_cfg_wr_data,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser,
    input logic       m_axis_tlast
);

    // A held beat without tlast means a replay is still pending
    `VOC_ASSERT_NOW(a_replay_blocks_input, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "input ready during replay")

    // Replay beats follow without a gap
    `VOC_ASSERT_NEXT(a_replay_no_gap, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "gap inside replay burst")

    // Every accepted character shows up in the result register next cycle
    `VOC_ASSERT_NEXT(a_accept_to_result, s_axis_tvalid && s_axis_tready, m_axis_tvalid, "accepted character lost")

    // A stalled result holds
    `VOC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

endmodule

bind variant_stream_overlap_chunker voc_sva u_voc_sva (.*);
